[design/dldc_pkg.sv]
// package for the desk lift drive controller
// types, codes and reset values shared by the interfaces and the rtl modules
`default_nettype none

package dldc_pkg;

  localparam int POS_W    = 13;
  localparam int MARGIN_W = 10;
  localparam int MS_CFG_W = 16;
  localparam int MS_W     = 32;
  localparam int REQ_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int EV_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EVENT = 2'd1;

  localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h55;
  localparam logic [BYTE_W-1:0] POS_ID_BYTE = 8'h92;

  localparam logic [EV_W-1:0] EV_PRESSED = 4'd4;
  localparam logic [EV_W-1:0] EV_TOGGLE  = 4'd12;

  localparam logic [CFG_IDX_W-1:0] REG_POS_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIT_POS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAND_POS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 3'd6;

  localparam logic [POS_W-1:0]    RST_POS_MIN     = 13'd170;
  localparam logic [POS_W-1:0]    RST_POS_MAX     = 13'd6400;
  localparam logic [POS_W-1:0]    RST_SIT_POS     = 13'd1800;
  localparam logic [POS_W-1:0]    RST_STAND_POS   = 13'd5700;
  localparam logic [MARGIN_W-1:0] RST_STOP_MARGIN = 10'd120;
  localparam logic [MS_CFG_W-1:0] RST_DEBOUNCE    = 16'd50;
  localparam logic [MS_CFG_W-1:0] RST_SHORT_PRESS = 16'd250;

  typedef struct packed {
    logic [POS_W-1:0]    pos_min;
    logic [POS_W-1:0]    pos_max;
    logic [POS_W-1:0]    sit_pos;
    logic [POS_W-1:0]    stand_pos;
    logic [MARGIN_W-1:0] stop_margin;
    logic [MS_CFG_W-1:0] debounce_ms;
    logic [MS_CFG_W-1:0] short_press_ms;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] rx_byte;
    logic              button_sel;
    logic [EV_W-1:0]   edge_events;
    logic [MS_W-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic             drive_down;
    logic             drive_up;
    logic [POS_W-1:0] cur_position;
  } out_item_t;

endpackage

`default_nettype wire

[design/dldc_if.sv]
// valid/ready channel interfaces for the desk lift drive controller
// depends on dldc_pkg for field widths
`default_nettype none

interface dldc_in_if;
  import dldc_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] rx_byte;
  logic              button_sel;
  logic [EV_W-1:0]   edge_events;
  logic [MS_W-1:0]   now_ms;

  modport source (output valid, req_type, rx_byte, button_sel, edge_events, now_ms,
                  input ready);
  modport sink (input valid, req_type, rx_byte, button_sel, edge_events, now_ms,
                output ready);
endinterface

interface dldc_out_if;
  import dldc_pkg::*;

  logic             valid;
  logic             ready;
  logic             drive_down;
  logic             drive_up;
  logic [POS_W-1:0] cur_position;

  modport source (output valid, drive_down, drive_up, cur_position, input ready);
  modport sink (input valid, drive_down, drive_up, cur_position, output ready);
endinterface

`default_nettype wire

[design/dldc_core.sv]
// controller state and single-pass step logic: frame decode, debounce, seek, drive
// depends on dldc_pkg
`default_nettype none

module dldc_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire dldc_pkg::in_item_t item,
  input  wire dldc_pkg::cfg_t     cfg,
  output dldc_pkg::out_item_t     result
);
  import dldc_pkg::*;

  logic [3*BYTE_W-1:0] hist_r, hist_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [1:0]          pressed_r, pressed_nxt;
  logic [MS_W-1:0]     last_r [2];
  logic [MS_W-1:0]     last_nxt [2];
  logic [1:0]          seek_r, seek_nxt;

  logic [2*BYTE_W-1:0] frame_pos;
  logic                frame_hit;
  logic                idx;
  logic [MS_W-1:0]     dur;
  logic                ev_val;
  logic [1:0]          seek_ev;
  logic [POS_W:0]      sit_lim;
  logic [POS_W:0]      up_sum;
  logic                gt_down;
  logic                lt_up;
  logic                down;
  logic                up;
  logic                clear_down;
  logic                clear_up;
  logic [1:0]          seek_mid;

  assign frame_pos = {item.rx_byte, hist_r[BYTE_W-1:0]};
  assign frame_hit = (hist_r[3*BYTE_W-1:2*BYTE_W] == SYNC_BYTE) &&
                     (hist_r[2*BYTE_W-1:BYTE_W] == POS_ID_BYTE);
  assign idx = item.button_sel;
  assign dur = item.now_ms - last_r[idx];

  always_comb begin
    if (item.edge_events == EV_PRESSED) begin
      ev_val = 1'b1;
    end else if (item.edge_events == EV_TOGGLE) begin
      ev_val = !pressed_r[idx];
    end else begin
      ev_val = 1'b0;
    end
  end

  always_comb begin
    hist_nxt    = hist_r;
    pos_nxt     = pos_r;
    pressed_nxt = pressed_r;
    last_nxt    = last_r;
    seek_ev     = seek_r;
    if (item.req_type == REQ_BYTE) begin
      hist_nxt = {hist_r[2*BYTE_W-1:0], item.rx_byte};
      if (frame_hit && frame_pos >= {3'b000, cfg.pos_min} &&
          frame_pos <= {3'b000, cfg.pos_max}) begin
        pos_nxt = frame_pos[POS_W-1:0];
      end
    end else if (item.req_type == REQ_EVENT) begin
      if (dur >= {16'h0000, cfg.debounce_ms}) begin
        pressed_nxt[idx] = ev_val;
        last_nxt[idx]    = item.now_ms;
        if (!ev_val && dur < {16'h0000, cfg.short_press_ms}) begin
          if (!idx && pos_r < cfg.stand_pos) begin
            seek_ev[0] = 1'b1;
          end
          if (idx && pos_r > cfg.sit_pos) begin
            seek_ev[1] = 1'b1;
          end
        end
      end
    end
  end

  // drive evaluation, down first
  assign sit_lim = {1'b0, cfg.sit_pos} + {4'b0000, cfg.stop_margin};
  assign up_sum  = {1'b0, pos_nxt} + {4'b0000, cfg.stop_margin};
  assign gt_down = {1'b0, pos_nxt} > sit_lim;
  assign lt_up   = up_sum < {1'b0, cfg.stand_pos};

  assign down       = pressed_nxt[1] || (seek_ev[1] && gt_down);
  assign clear_down = pressed_nxt[1] || (seek_ev[1] && !gt_down);
  assign seek_mid   = clear_down ? 2'b00 : seek_ev;
  assign up         = !down && (pressed_nxt[0] || (seek_mid[0] && lt_up));
  assign clear_up   = !down && (pressed_nxt[0] || (seek_mid[0] && !lt_up));
  assign seek_nxt   = clear_up ? 2'b00 : seek_mid;

  assign result.drive_down   = down;
  assign result.drive_up     = up;
  assign result.cur_position = pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r    <= '0;
      pos_r     <= '0;
      pressed_r <= '0;
      last_r[0] <= '0;
      last_r[1] <= '0;
      seek_r    <= '0;
    end else if (step_en) begin
      hist_r    <= hist_nxt;
      pos_r     <= pos_nxt;
      pressed_r <= pressed_nxt;
      last_r[0] <= last_nxt[0];
      last_r[1] <= last_nxt[1];
      seek_r    <= seek_nxt;
    end
  end

endmodule

`default_nettype wire

[design/desk_lift_drive_controller_top.sv]
// top level of the desk lift drive controller: config registers, input and result registers
// depends on dldc_pkg, dldc_if and dldc_core
`default_nettype none

// Desk lift drive controller. Each input transaction is a bus byte, a button
// edge event or a poll, and each gives exactly one result transaction with the
// down/up drive and the last valid bus position. One transaction is taken per
// clock unless the input register stalls; a transaction is held in the input
// register, processed in a single pass by the core logic, and its result is
// loaded into the result register once that register is free or being taken. The
// input register stalls only while it holds a transaction and a result waits to
// be taken. Configuration registers are written through the cfg_ port; the user
// must write them only while no transaction is in flight; the block does not enforce it.
module desk_lift_drive_controller_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dldc_in_if.sink                                in_if,
  dldc_out_if.source                             out_if,
  input  wire logic                              cfg_we,
  input  wire logic [dldc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [dldc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dldc_pkg::*;

  cfg_t      cfg_r;
  in_item_t  item_r;
  logic      item_vld_r;
  out_item_t res_r;
  out_item_t res_nxt;
  logic      res_vld_r;
  logic      advance;

  assign advance     = !res_vld_r || out_if.ready;
  assign in_if.ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_min        <= RST_POS_MIN;
      cfg_r.pos_max        <= RST_POS_MAX;
      cfg_r.sit_pos        <= RST_SIT_POS;
      cfg_r.stand_pos      <= RST_STAND_POS;
      cfg_r.stop_margin    <= RST_STOP_MARGIN;
      cfg_r.debounce_ms    <= RST_DEBOUNCE;
      cfg_r.short_press_ms <= RST_SHORT_PRESS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_POS_MIN:     cfg_r.pos_min        <= cfg_wdata[POS_W-1:0];
        REG_POS_MAX:     cfg_r.pos_max        <= cfg_wdata[POS_W-1:0];
        REG_SIT_POS:     cfg_r.sit_pos        <= cfg_wdata[POS_W-1:0];
        REG_STAND_POS:   cfg_r.stand_pos      <= cfg_wdata[POS_W-1:0];
        REG_STOP_MARGIN: cfg_r.stop_margin    <= cfg_wdata[MARGIN_W-1:0];
        REG_DEBOUNCE:    cfg_r.debounce_ms    <= cfg_wdata[MS_CFG_W-1:0];
        REG_SHORT_PRESS: cfg_r.short_press_ms <= cfg_wdata[MS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_if.ready) begin
        item_vld_r <= in_if.valid;
      end
      if (advance) begin
        res_vld_r <= item_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.req_type    <= in_if.req_type;
      item_r.rx_byte     <= in_if.rx_byte;
      item_r.button_sel  <= in_if.button_sel;
      item_r.edge_events <= in_if.edge_events;
      item_r.now_ms      <= in_if.now_ms;
    end
    if (advance && item_vld_r) begin
      res_r <= res_nxt;
    end
  end

  dldc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(advance && item_vld_r),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (res_nxt)
  );

  assign out_if.valid        = res_vld_r;
  assign out_if.drive_down   = res_r.drive_down;
  assign out_if.drive_up     = res_r.drive_up;
  assign out_if.cur_position = res_r.cur_position;

endmodule

`default_nettype wire

[dv/desk_lift_drive_controller_top_test.sv]
// self-checking testbench for desk_lift_drive_controller_top
// drives bus byte, button and poll transactions, predicts every result in place
// depends on dldc_pkg, dldc_if and the rtl under design/
`default_nettype none

module desk_lift_drive_controller_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dldc_pkg::*;

  localparam logic [REQ_W-1:0] REQ_POLL    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SPARE   = 2'd3;
  localparam logic [EV_W-1:0]  EV_RELEASED = 4'd0;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 150;
  localparam int CYCLE_LIMIT   = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dldc_in_if  in_ch ();
  dldc_out_if out_ch ();

  desk_lift_drive_controller_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  in_item_t  pending_items[$];
  out_item_t drive_expect_q[$];

  // predicted controller state
  cfg_t        drive_cfg;
  logic [23:0] bus_hist;
  logic [12:0] cur_pos;
  logic        btn_held [2];
  logic [31:0] btn_last_ms [2];
  logic        seek_req [2];

  logic [31:0] ms_clock;
  logic        src_idle_on = 1'b0;
  logic        sink_idle_on = 1'b0;
  int          src_gap;
  int          sink_wait;
  int          hold_req_cnt = 0;
  int          hold_done_cnt = 0;
  int          cycle_cnt = 0;
  int          queued = 0;
  int          fails = 0;
  int          settings_used = 1;
  int          bytes_taken = 0;
  int          events_taken = 0;
  int          polls_taken = 0;
  int          down_seen = 0;
  int          up_seen = 0;

  function automatic out_item_t drive_step(in_item_t it);
    out_item_t   r;
    logic [15:0] frame_pos;
    logic [31:0] dur;
    logic        lvl;
    logic        dn;
    logic        up;
    logic        b;
    dn = 1'b0;
    up = 1'b0;
    if (it.req_type == REQ_BYTE) begin
      if (bus_hist[23:16] == SYNC_BYTE && bus_hist[15:8] == POS_ID_BYTE) begin
        frame_pos = {it.rx_byte, bus_hist[7:0]};
        if (frame_pos >= {3'b000, drive_cfg.pos_min} &&
            frame_pos <= {3'b000, drive_cfg.pos_max})
          cur_pos = frame_pos[12:0];
      end
      bus_hist = {bus_hist[15:0], it.rx_byte};
    end else if (it.req_type == REQ_EVENT) begin
      b = it.button_sel;
      dur = it.now_ms - btn_last_ms[b];
      if (dur >= {16'h0000, drive_cfg.debounce_ms}) begin
        if (it.edge_events == EV_PRESSED) begin
          lvl = 1'b1;
        end else if (it.edge_events == EV_TOGGLE) begin
          lvl = !btn_held[b];
        end else begin
          lvl = 1'b0;
        end
        btn_held[b] = lvl;
        btn_last_ms[b] = it.now_ms;
        if (!lvl && dur < {16'h0000, drive_cfg.short_press_ms}) begin
          if (!b && cur_pos < drive_cfg.stand_pos) seek_req[0] = 1'b1;
          if (b && cur_pos > drive_cfg.sit_pos) seek_req[1] = 1'b1;
        end
      end
    end
    // down first, it has priority
    if (btn_held[1]) begin
      seek_req[0] = 1'b0;
      seek_req[1] = 1'b0;
      dn = 1'b1;
    end else if (seek_req[1]) begin
      if (int'(cur_pos) > int'(drive_cfg.sit_pos) + int'(drive_cfg.stop_margin)) begin
        dn = 1'b1;
      end else begin
        seek_req[0] = 1'b0;
        seek_req[1] = 1'b0;
      end
    end
    if (!dn) begin
      if (btn_held[0]) begin
        seek_req[0] = 1'b0;
        seek_req[1] = 1'b0;
        up = 1'b1;
      end else if (seek_req[0]) begin
        if (int'(cur_pos) + int'(drive_cfg.stop_margin) < int'(drive_cfg.stand_pos)) begin
          up = 1'b1;
        end else begin
          seek_req[0] = 1'b0;
          seek_req[1] = 1'b0;
        end
      end
    end
    r.drive_down = dn;
    r.drive_up = up;
    r.cur_position = cur_pos;
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap != 0) begin
        in_ch.valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pending_items.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.req_type <= pending_items[0].req_type;
        in_ch.rx_byte <= pending_items[0].rx_byte;
        in_ch.button_sel <= pending_items[0].button_sel;
        in_ch.edge_events <= pending_items[0].edge_events;
        in_ch.now_ms <= pending_items[0].now_ms;
        void'(pending_items.pop_front());
        src_gap <= src_idle_on ? $urandom_range(0, 4) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with random stalls and the occasional long hold
  always @(posedge clk) begin : sink_ctl
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait <= 0;
    end else if (hold_req_cnt != hold_done_cnt) begin
      out_ch.ready <= 1'b0;
      sink_wait <= LONG_HOLD;
      hold_done_cnt <= hold_done_cnt + 1;
    end else if (sink_wait != 0) begin
      out_ch.ready <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else if (out_ch.valid && out_ch.ready && sink_idle_on) begin
      w = $urandom_range(0, 4);
      out_ch.ready <= (w == 0);
      sink_wait <= (w == 0) ? 0 : w - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // prediction on input transactions, checking on result transactions
  always @(posedge clk) begin : result_check
    in_item_t  seen;
    out_item_t got;
    out_item_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.req_type = in_ch.req_type;
        seen.rx_byte = in_ch.rx_byte;
        seen.button_sel = in_ch.button_sel;
        seen.edge_events = in_ch.edge_events;
        seen.now_ms = in_ch.now_ms;
        drive_expect_q.push_back(drive_step(seen));
        if (seen.req_type == REQ_BYTE) bytes_taken++;
        else if (seen.req_type == REQ_EVENT) events_taken++;
        else polls_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.drive_down = out_ch.drive_down;
        got.drive_up = out_ch.drive_up;
        got.cur_position = out_ch.cur_position;
        if (got.drive_down === 1'b1) down_seen++;
        if (got.drive_up === 1'b1) up_seen++;
        if (drive_expect_q.size() == 0) begin
          $display("%0t: unexpected result transaction, actual down %0d up %0d position %0d",
                   $time, got.drive_down, got.drive_up, got.cur_position);
          fails++;
        end else begin
          want = drive_expect_q.pop_front();
          if (got.drive_down !== want.drive_down) begin
            $display("%0t: drive_down mismatch, expected %0d actual %0d",
                     $time, want.drive_down, got.drive_down);
            fails++;
          end
          if (got.drive_up !== want.drive_up) begin
            $display("%0t: drive_up mismatch, expected %0d actual %0d",
                     $time, want.drive_up, got.drive_up);
            fails++;
          end
          if (got.cur_position !== want.cur_position) begin
            $display("%0t: cur_position mismatch, expected %0d actual %0d",
                     $time, want.cur_position, got.cur_position);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, drive_expect_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void queue_item(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] b, logic sel,
                                     logic [EV_W-1:0] ev, logic [MS_W-1:0] now);
    in_item_t it;
    it.req_type = req;
    it.rx_byte = b;
    it.button_sel = sel;
    it.edge_events = ev;
    it.now_ms = now;
    pending_items.push_back(it);
    queued++;
  endfunction

  function automatic void queue_byte(logic [BYTE_W-1:0] b);
    queue_item(REQ_BYTE, b, 1'($urandom), 4'($urandom), $urandom);
  endfunction

  function automatic void queue_event(logic sel, logic [EV_W-1:0] ev, logic [MS_W-1:0] now);
    queue_item(REQ_EVENT, 8'($urandom), sel, ev, now);
  endfunction

  function automatic void queue_poll(logic [REQ_W-1:0] req);
    queue_item(req, 8'($urandom), 1'($urandom), 4'($urandom), $urandom);
  endfunction

  // sync, id, lsb, msb with polls mixed in and now and then a corrupted byte
  function automatic void queue_frame(logic [15:0] pos);
    logic [7:0] seq [4];
    seq = '{SYNC_BYTE, POS_ID_BYTE, pos[7:0], pos[15:8]};
    if ($urandom_range(0, 7) == 0) seq[2'($urandom_range(0, 3))] = 8'($urandom);
    foreach (seq[k]) begin
      if ($urandom_range(0, 5) == 0) queue_poll($urandom_range(0, 1) ? REQ_POLL : REQ_SPARE);
      queue_byte(seq[k]);
    end
  endfunction

  // positions biased toward the limits and the stop points
  function automatic logic [15:0] pick_pos();
    int p;
    case ($urandom_range(0, 5))
      0: p = $urandom_range(0, 65535);
      1: p = (drive_cfg.pos_min <= drive_cfg.pos_max) ?
             $urandom_range(drive_cfg.pos_min, drive_cfg.pos_max) : $urandom_range(0, 8191);
      2: p = drive_cfg.sit_pos + drive_cfg.stop_margin + $urandom_range(0, 6) - 3;
      3: p = drive_cfg.stand_pos - drive_cfg.stop_margin + $urandom_range(0, 6) - 3;
      4: p = ($urandom_range(0, 1) ? drive_cfg.pos_min : drive_cfg.pos_max)
             + $urandom_range(0, 2) - 1;
      default: p = $urandom_range(0, 8191);
    endcase
    return p[15:0];
  endfunction

  task automatic add_traffic(int n);
    int          goal;
    int          r;
    logic        sel;
    logic [3:0]  ev;
    goal = queued + n;
    while (queued < goal) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        queue_frame(pick_pos());
      end else if (r < 65) begin
        sel = 1'($urandom_range(0, 1));
        ms_clock += $urandom_range(0, 600);
        queue_event(sel, $urandom_range(0, 1) ? EV_PRESSED : EV_TOGGLE, ms_clock);
        if ($urandom_range(0, 2) == 0) queue_frame(pick_pos());
        ms_clock += $urandom_range(0, 400);
        ev = 4'($urandom_range(0, 15));
        if (ev == EV_PRESSED) ev = EV_RELEASED;
        queue_event(sel, ev, ms_clock);
      end else if (r < 80) begin
        repeat ($urandom_range(1, 3))
          queue_poll($urandom_range(0, 1) ? REQ_POLL : REQ_SPARE);
      end else begin
        repeat ($urandom_range(1, 3))
          queue_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 4'($urandom),
                     $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_ch.valid || drive_expect_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_POS_MIN:     drive_cfg.pos_min = value[POS_W-1:0];
      REG_POS_MAX:     drive_cfg.pos_max = value[POS_W-1:0];
      REG_SIT_POS:     drive_cfg.sit_pos = value[POS_W-1:0];
      REG_STAND_POS:   drive_cfg.stand_pos = value[POS_W-1:0];
      REG_STOP_MARGIN: drive_cfg.stop_margin = value[MARGIN_W-1:0];
      REG_DEBOUNCE:    drive_cfg.debounce_ms = value[MS_CFG_W-1:0];
      REG_SHORT_PRESS: drive_cfg.short_press_ms = value[MS_CFG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(int mn, int mx, int sit, int stand, int margin, int deb, int shp);
    set_reg(REG_POS_MIN, mn);
    set_reg(REG_POS_MAX, mx);
    set_reg(REG_SIT_POS, sit);
    set_reg(REG_STAND_POS, stand);
    set_reg(REG_STOP_MARGIN, margin);
    set_reg(REG_DEBOUNCE, deb);
    set_reg(REG_SHORT_PRESS, shp);
    settings_used++;
  endtask

  task automatic run_phase(int n, logic idle);
    src_idle_on = idle && ($urandom_range(0, 3) != 0);
    sink_idle_on = idle && ($urandom_range(0, 3) != 0);
    ms_clock = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FC00 + $urandom_range(0, 1023);
    add_traffic(n);
    wait_idle();
  endtask

  initial begin : stimulus
    int lo;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.rx_byte = '0;
    in_ch.button_sel = 1'b0;
    in_ch.edge_events = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    drive_cfg = '{RST_POS_MIN, RST_POS_MAX, RST_SIT_POS, RST_STAND_POS,
                  RST_STOP_MARGIN, RST_DEBOUNCE, RST_SHORT_PRESS};
    bus_hist = '0;
    cur_pos = '0;
    btn_held = '{1'b0, 1'b0};
    btn_last_ms = '{32'd0, 32'd0};
    seek_req = '{1'b0, 1'b0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed transactions on reset settings
    queue_poll(REQ_POLL);
    queue_poll(REQ_SPARE);
    queue_frame_fixed: begin
      queue_byte(SYNC_BYTE); queue_byte(POS_ID_BYTE); queue_byte(8'hE8); queue_byte(8'h03);
      // above 13 bits
      queue_byte(SYNC_BYTE); queue_byte(POS_ID_BYTE); queue_byte(8'h00); queue_byte(8'hFF);
      // overlapping frames, the second one is valid
      queue_byte(SYNC_BYTE); queue_byte(POS_ID_BYTE); queue_byte(SYNC_BYTE);
      queue_byte(POS_ID_BYTE); queue_byte(8'h40); queue_byte(8'h06);
    end
    queue_event(1'b0, EV_PRESSED, 32'd20);
    queue_event(1'b0, EV_PRESSED, 32'd100);
    queue_event(1'b0, EV_RELEASED, 32'd150);
    queue_poll(REQ_POLL);
    queue_event(1'b1, EV_TOGGLE, 32'd1000);
    queue_event(1'b1, EV_TOGGLE, 32'd1100);
    queue_event(1'b1, 4'hF, 32'hFFFF_FFFF);
    // above pos_max
    queue_byte(SYNC_BYTE); queue_byte(POS_ID_BYTE); queue_byte(8'hFF); queue_byte(8'h1F);

    ms_clock = 32'd2000;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    hold_req_cnt++;
    add_traffic(250);
    wait_idle();

    program_regs(0, 8191, 0, 8191, 0, 0, 65535);
    run_phase(250, 1'b0);
    // inverted limits, widest margin and debounce
    program_regs(8191, 0, 8191, 0, 1023, 65535, 0);
    run_phase(150, 1'b1);
    for (int k = 0; k < 5; k++) begin
      lo = $urandom_range(0, 4000);
      program_regs(lo, $urandom_range(lo, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 8191), $urandom_range(0, 1023),
                   $urandom_range(0, 400), $urandom_range(0, 1000));
      if (k == 2) hold_req_cnt++;
      run_phase(210, 1'b1);
    end

    $display("covered %0d transactions (%0d bus bytes, %0d button events, %0d polls)",
             bytes_taken + events_taken + polls_taken, bytes_taken, events_taken, polls_taken);
    $display("over %0d register settings; %0d down and %0d up drive results, %0d long holds",
             settings_used, down_seen, up_seen, hold_done_cnt);
    if (fails == 0 && drive_expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

[desk_lift_drive_controller_top.f]
design/dldc_pkg.sv
design/dldc_if.sv
design/dldc_core.sv
design/desk_lift_drive_controller_top.sv
dv/desk_lift_drive_controller_top_test.sv
